[hw/rtl/shell_subpacket_deframer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Shell sub-packet deframer assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHELL_SUBPACKET_DEFRAMER_UNIT_DEFINES_SVH
`define SHELL_SUBPACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and constants of the shell sub-packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned HLEN_W = 32;
  localparam int unsigned IDX_W  = 3;

  // Payload length clamp and header size
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_BYTES = LEN_W'(4096);
  localparam logic [LEN_W-1:0] HEADER_BYTES      = LEN_W'(5);
  localparam logic [LEN_W-1:0] OUT_MAX_RESET     = LEN_W'(4096);

  // Register map
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_OUT_MAX = 1'b0;

  // Header byte counter codes
  localparam logic [IDX_W-1:0] HDR_ID    = IDX_W'(0);
  localparam logic [IDX_W-1:0] HDR_LEN0  = IDX_W'(1);
  localparam logic [IDX_W-1:0] HDR_LEN1  = IDX_W'(2);
  localparam logic [IDX_W-1:0] HDR_LEN2  = IDX_W'(3);
  localparam logic [IDX_W-1:0] HDR_LAST  = IDX_W'(4);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/shell_subpacket_deframer_unit.sv]
// An accepted input reaches the result through the input register and the result register.
// Throughput: 1 item per cycle while out_stall is low; the deframing state updates in a single pass.
// Items that produce no result (header and skipped bytes) leave no output.
// Reset (synchronous, rst_n low): empties both stages, puts the deframer in the
// header phase at payload byte 0 and sets out_max to 4096.
// ----------------------------------------------------------------------------
// shell_subpacket_deframer_unit
// Splits a payload stream into sub-packets (id, 4-byte LE length, data) and
// emits the data bytes with an end-of-payload status and total.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_subpacket_deframer_unit_defines.svh"

module shell_subpacket_deframer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ssd_pkg::BYTE_W-1:0]    in_payload_byte,
  input  wire logic [ssd_pkg::LEN_W-1:0]     in_payload_length,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ssd_pkg::BYTE_W-1:0]         out_data_byte,
  output logic                               out_data_valid,
  output logic                               out_done_res,
  output logic [1:0]                         out_status,
  output logic [ssd_pkg::LEN_W-1:0]          out_total_length,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ssd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned LW = ssd_pkg::LEN_W;
  localparam int unsigned HW = ssd_pkg::HLEN_W;

  // configuration register
  logic [LW-1:0] out_max_r;
  logic          cfg_sel;

  // input stage
  logic                       s1_vld_r;
  logic [ssd_pkg::BYTE_W-1:0] s1_byte_r;
  logic [LW-1:0]              s1_len_r;
  logic                       s1_load;
  logic [LW-1:0]              len_clamp;

  // deframing state
  ssd_pkg::phase_t            phase_r,   phase_nxt;
  logic [LW-1:0]              pos_r,     pos_nxt;
  logic [ssd_pkg::IDX_W-1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [HW-1:0]              acc_r,     acc_nxt;
  logic [HW-1:0]              rem_r,     rem_nxt;
  logic [LW-1:0]              ext_r,     ext_nxt;
  ssd_pkg::status_t           err_r,     err_nxt;

  // result stage
  logic                       out_vld_r;
  logic [ssd_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_dvld_r;
  logic                       out_done_r;
  ssd_pkg::status_t           out_st_r;
  logic [LW-1:0]              out_tot_r;

  // single-pass results
  logic                       adv;
  logic                       fire;
  logic                       res_dvld;
  logic                       res_done;
  ssd_pkg::status_t           res_st;
  logic [LW-1:0]              res_tot;
  logic                       short_tail;
  logic                       end_hit;
  logic                       trunc_hit;
  logic                       ovfl_hit;
  logic [HW-1:0]              hdr_len;
  ssd_pkg::phase_t            ph_eff;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ssd_pkg::PADDR_W-1] == ssd_pkg::REG_OUT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_max_r <= ssd_pkg::OUT_MAX_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      out_max_r <= pwdata[LW-1:0];
    end
  end

  // Return the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = {{(32-LW){1'b0}}, out_max_r};
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: advance the pipe when the result register is free or drained
  // --------------------------------------------------------------------------
  assign adv      = !out_vld_r || !out_stall;
  assign s1_load  = adv || !s1_vld_r;
  assign in_stall = !s1_load;
  assign fire     = adv && s1_vld_r;

  // Clamp oversized payload lengths
  assign len_clamp = (in_payload_length > ssd_pkg::MAX_PAYLOAD_BYTES) ?
                     ssd_pkg::MAX_PAYLOAD_BYTES : in_payload_length;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_load) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_payload_byte;
      s1_len_r  <= len_clamp;
    end
  end

  // --------------------------------------------------------------------------
  // Deframe one byte
  // --------------------------------------------------------------------------
  // Full sub-packet length once the last header byte is in
  assign hdr_len    = {s1_byte_r, acc_r[23:0]};
  assign short_tail = ({1'b0, pos_r} + {1'b0, ssd_pkg::HEADER_BYTES}) > {1'b0, s1_len_r};
  assign end_hit    = ({1'b0, pos_r} + (LW+1)'(1)) >= {1'b0, s1_len_r};
  assign trunc_hit  = ({{(HW-LW+2){1'b0}}, pos_r} + (HW+2)'(1) + {2'b00, hdr_len}) >
                      {{(HW-LW+2){1'b0}}, s1_len_r};
  assign ovfl_hit   = ({{(HW-LW+1){1'b0}}, ext_r} + {1'b0, hdr_len}) >
                      {{(HW-LW+1){1'b0}}, out_max_r};

  always_comb begin
    ph_eff      = phase_r;
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    ext_nxt     = ext_r;
    err_nxt     = err_r;
    pos_nxt     = pos_r + LW'(1);
    res_dvld    = 1'b0;
    res_done    = 1'b0;
    res_st      = ssd_pkg::ST_OK;
    res_tot     = '0;

    // Skip a tail too short for a header
    if (phase_r == ssd_pkg::PH_HEADER && hdr_idx_r == ssd_pkg::HDR_ID && short_tail) begin
      ph_eff = ssd_pkg::PH_SKIP;
    end
    phase_nxt = ph_eff;

    case (ph_eff)
      ssd_pkg::PH_HEADER: begin
        // Assemble the little-endian length, one lane per byte
        case (hdr_idx_r)
          ssd_pkg::HDR_ID:   acc_nxt = '0;
          ssd_pkg::HDR_LEN0: acc_nxt[7:0]   = s1_byte_r;
          ssd_pkg::HDR_LEN1: acc_nxt[15:8]  = s1_byte_r;
          ssd_pkg::HDR_LEN2: acc_nxt[23:16] = s1_byte_r;
          default:           acc_nxt[31:24] = s1_byte_r;
        endcase
        if (hdr_idx_r == ssd_pkg::HDR_ID) begin
          hdr_idx_nxt = ssd_pkg::HDR_LEN0;
        end else if (hdr_idx_r >= ssd_pkg::HDR_LAST) begin
          // Header done: check payload end, then output capacity
          hdr_idx_nxt = ssd_pkg::HDR_ID;
          if (trunc_hit) begin
            err_nxt   = ssd_pkg::ST_TRUNC;
            phase_nxt = ssd_pkg::PH_SKIP;
          end else if (ovfl_hit) begin
            err_nxt   = ssd_pkg::ST_OVERFLOW;
            phase_nxt = ssd_pkg::PH_SKIP;
          end else begin
            rem_nxt   = hdr_len;
            phase_nxt = (hdr_len == '0) ? ssd_pkg::PH_HEADER : ssd_pkg::PH_DATA;
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + ssd_pkg::IDX_W'(1);
        end
      end
      ssd_pkg::PH_DATA: begin
        // Emit the data byte and count it down
        res_dvld = 1'b1;
        ext_nxt  = ext_r + LW'(1);
        if (rem_r != '0) begin
          rem_nxt = rem_r - HW'(1);
        end
        if (rem_nxt == '0) begin
          phase_nxt = ssd_pkg::PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    // End of payload: report and clear the per-payload state
    if (end_hit) begin
      res_done    = 1'b1;
      res_st      = err_nxt;
      res_tot     = (err_nxt != ssd_pkg::ST_OK) ? '0 : ext_nxt;
      pos_nxt     = '0;
      phase_nxt   = ssd_pkg::PH_HEADER;
      hdr_idx_nxt = ssd_pkg::HDR_ID;
      acc_nxt     = '0;
      rem_nxt     = '0;
      ext_nxt     = '0;
      err_nxt     = ssd_pkg::ST_OK;
    end
  end

  // Advance the deframing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ssd_pkg::PH_HEADER;
      pos_r     <= '0;
      hdr_idx_r <= ssd_pkg::HDR_ID;
      acc_r     <= '0;
      rem_r     <= '0;
      ext_r     <= '0;
      err_r     <= ssd_pkg::ST_OK;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
      ext_r     <= ext_nxt;
      err_r     <= err_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fire && (res_dvld || res_done);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= res_dvld ? s1_byte_r : '0;
      out_dvld_r <= res_dvld;
      out_done_r <= res_done;
      out_st_r   <= res_st;
      out_tot_r  <= res_tot;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_data_byte    = out_byte_r;
  assign out_data_valid   = out_dvld_r;
  assign out_done_res     = out_done_r;
  assign out_status       = out_st_r;
  assign out_total_length = out_tot_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SSD_ASSERT_NOW(a_data_hdr_idle, phase_r == ssd_pkg::PH_DATA,
                  hdr_idx_r == ssd_pkg::HDR_ID, "header counter busy in data phase")
  `SSD_ASSERT_NOW(a_err_skips, err_r != ssd_pkg::ST_OK,
                  phase_r == ssd_pkg::PH_SKIP, "error latched outside skip phase")
  `SSD_ASSERT_NOW(a_err_total, out_vld_r && out_done_r && out_st_r != ssd_pkg::ST_OK,
                  out_tot_r == '0, "nonzero total on error status")
  `SSD_ASSERT_NOW(a_no_empty_result, out_vld_r && !out_dvld_r,
                  out_done_r && out_byte_r == '0, "result carries neither data nor done")
  `SSD_ASSERT_NEXT(a_done_clears, fire && end_hit,
                   pos_r == '0 && ext_r == '0, "payload state not cleared at end")

endmodule

`default_nettype wire
